// File: hw/rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, constants and tables for the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int SQRT_STEPS = 32;

	typedef logic signed [33:0] xy_t;
	typedef logic signed [32:0] ang_t;

	typedef struct packed {
		xy_t  x;
		xy_t  y;
		ang_t z;
		logic neg;
	} rot_lane_t;

	typedef rot_lane_t [2:0] rot_row_t;

	typedef struct packed {
		logic [60:0] rem;
		logic [60:0] root;
		logic [30:0] mag;
		logic        vneg;
	} sqrt_t;

	typedef struct packed {
		xy_t  x;
		xy_t  y;
		ang_t z;
		logic vneg;
	} vec_t;

	localparam logic [1:0] UNIT_MI = 2'd0;
	localparam logic [1:0] UNIT_KM = 2'd1;
	localparam logic [1:0] UNIT_NM = 2'd2;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [25:0] DEG_TO_RAD = 26'sd18740330;
	localparam logic signed [24:0] DEG90 = 25'sd5898240;
	localparam logic signed [24:0] DEG180 = 25'sd11796480;
	localparam logic [25:0] DEG180_U = 26'd11796480;
	localparam logic [25:0] DEG360_U = 26'd23592960;
	localparam logic signed [34:0] Q30_ONE = 35'sd1073741824;
	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
	localparam logic [60:0] Q60_ONE = 61'd1 << 60;
	localparam logic [23:0] OUT_MAX = 24'd8388607;

	function automatic ang_t atan_q30(input logic [4:0] i);
		ang_t r;
		case (i)
			5'd0:    r = 33'sh3243F6A8;
			5'd1:    r = 33'sh1DAC6705;
			5'd2:    r = 33'sh0FADBAFC;
			5'd3:    r = 33'sh07F56EA6;
			5'd4:    r = 33'sh03FEAB76;
			5'd5:    r = 33'sh01FFD55B;
			5'd6:    r = 33'sh00FFFAAA;
			5'd7:    r = 33'sh007FFF55;
			5'd8:    r = 33'sh003FFFEA;
			5'd9:    r = 33'sh001FFFFD;
			5'd10:   r = 33'sh000FFFFF;
			5'd11:   r = 33'sh0007FFFF;
			5'd12:   r = 33'sh0003FFFF;
			5'd13:   r = 33'sh0001FFFF;
			5'd14:   r = 33'sh0000FFFF;
			5'd15:   r = 33'sh00007FFF;
			5'd16:   r = 33'sh00003FFF;
			5'd17:   r = 33'sh00001FFF;
			5'd18:   r = 33'sh00000FFF;
			5'd19:   r = 33'sh000007FF;
			5'd20:   r = 33'sh000003FF;
			5'd21:   r = 33'sh000001FF;
			5'd22:   r = 33'sh000000FF;
			5'd23:   r = 33'sh0000007F;
			5'd24:   r = 33'sh0000003F;
			5'd25:   r = 33'sh0000001F;
			5'd26:   r = 33'sh0000000F;
			5'd27:   r = 33'sh00000008;
			5'd28:   r = 33'sh00000004;
			5'd29:   r = 33'sh00000002;
			5'd30:   r = 33'sh00000001;
			default: r = 33'sh00000000;
		endcase
		return r;
	endfunction

	function automatic logic [28:0] unit_factor(input logic [1:0] u);
		logic [28:0] f;
		case (u)
			UNIT_KM: f = 29'd417509768;
			UNIT_NM: f = 29'd225287746;
			default: f = 29'd259428542;
		endcase
		return f;
	endfunction

endpackage

// File: hw/rtl/gcd_rot_cell.sv
// ----------------------------------------------------------------------------
// gcd_rot_cell
// One CORDIC rotation step on three lanes, registered.
// ----------------------------------------------------------------------------
module gcd_rot_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [4:0]        step,
	input  logic              vld_in,
	input  gcd_pkg::rot_row_t row_in,
	output logic              vld_q,
	output gcd_pkg::rot_row_t row_q
);
	import gcd_pkg::*;

	rot_row_t row_d;
	ang_t     at;

	always_comb begin
		at = atan_q30(step);
		for (int k = 0; k < 3; k++) begin
			row_d[k].neg = row_in[k].neg;
			if (!row_in[k].z[32]) begin
				row_d[k].x = row_in[k].x - ($signed(row_in[k].y) >>> step);
				row_d[k].y = row_in[k].y + ($signed(row_in[k].x) >>> step);
				row_d[k].z = row_in[k].z - at;
			end else begin
				row_d[k].x = row_in[k].x + ($signed(row_in[k].y) >>> step);
				row_d[k].y = row_in[k].y - ($signed(row_in[k].x) >>> step);
				row_d[k].z = row_in[k].z + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_q <= row_d;
		end
	end

endmodule

// File: hw/rtl/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [4:0]     step,
	input  logic           vld_in,
	input  gcd_pkg::sqrt_t sq_in,
	output logic           vld_q,
	output gcd_pkg::sqrt_t sq_q
);
	import gcd_pkg::*;

	sqrt_t       sq_d;
	logic [62:0] bitv;
	logic [62:0] trial;

	always_comb begin
		bitv  = 63'd1 << (6'd62 - {step, 1'b0});
		trial = {2'b00, sq_in.root} + bitv;
		sq_d  = sq_in;
		if ({2'b00, sq_in.rem} >= trial) begin
			sq_d.rem  = sq_in.rem - trial[60:0];
			sq_d.root = (sq_in.root >> 1) + bitv[60:0];
		end else begin
			sq_d.root = sq_in.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q <= sq_d;
		end
	end

endmodule

// File: hw/rtl/gcd_vec_cell.sv
// ----------------------------------------------------------------------------
// gcd_vec_cell
// One CORDIC vectoring step for the arccosine, registered.
// ----------------------------------------------------------------------------
module gcd_vec_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [4:0]    step,
	input  logic          vld_in,
	input  gcd_pkg::vec_t vec_in,
	output logic          vld_q,
	output gcd_pkg::vec_t vec_q
);
	import gcd_pkg::*;

	vec_t vec_d;
	ang_t at;

	always_comb begin
		at         = atan_q30(step);
		vec_d.vneg = vec_in.vneg;
		if (!vec_in.y[33] && (vec_in.y != '0)) begin
			vec_d.x = vec_in.x + ($signed(vec_in.y) >>> step);
			vec_d.y = vec_in.y - ($signed(vec_in.x) >>> step);
			vec_d.z = vec_in.z + at;
		end else begin
			vec_d.x = vec_in.x - ($signed(vec_in.y) >>> step);
			vec_d.y = vec_in.y + ($signed(vec_in.x) >>> step);
			vec_d.z = vec_in.z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_q <= vec_d;
		end
	end

endmodule

// File: hw/rtl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Spherical law of cosines distance with CORDIC sin/cos, isqrt and acos.
//
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    first_lat first_lon second_lat second_lon
// out      out  out_valid / out_ready  path_length
// cfg      in   cfg_valid / cfg_ready  cfg_data (distance_unit)
//
// One item per cycle while the output is not stalled; the pipeline depth is set by the CORDIC
// rotation chain, the 32-step square root chain and the vectoring chain.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears all valid bits and sets the unit to kilometres.
// ----------------------------------------------------------------------------
module great_circle_distance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] first_lat,
	input  logic [24:0] first_lon,
	input  logic [23:0] second_lat,
	input  logic [24:0] second_lon,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [22:0] path_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);
	import gcd_pkg::*;

	logic       en;
	logic [1:0] distance_unit_q;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_unit_q <= UNIT_KM;
		end else if (cfg_valid) begin
			distance_unit_q <= cfg_data;
		end
	end

	// fold angles
	logic signed [25:0] dlon;
	logic [25:0]        dmag;
	logic [25:0]        dred;
	logic [25:0]        dfold;
	logic signed [24:0] lat_a;
	logic signed [24:0] lat_b;
	logic signed [24:0] ang_d [3];
	logic               neg_d [3];

	always_comb begin
		dlon  = {first_lon[24], first_lon} - {second_lon[24], second_lon};
		dmag  = dlon[25] ? 26'(-dlon) : 26'(dlon);
		dred  = (dmag >= DEG360_U) ? dmag - DEG360_U : dmag;
		dfold = (dred > DEG180_U) ? DEG360_U - dred : dred;
		lat_a = 25'($signed(first_lat));
		lat_b = 25'($signed(second_lat));
		for (int k = 0; k < 2; k++) begin
			logic signed [24:0] a;
			a = (k == 0) ? lat_a : lat_b;
			if (a > DEG90) begin
				ang_d[k] = DEG180 - a;
				neg_d[k] = 1'b1;
			end else if (a < -DEG90) begin
				ang_d[k] = -DEG180 - a;
				neg_d[k] = 1'b1;
			end else begin
				ang_d[k] = a;
				neg_d[k] = 1'b0;
			end
		end
		if (dfold > DEG90) begin
			ang_d[2] = DEG180 - $signed(dfold[24:0]);
			neg_d[2] = 1'b1;
		end else begin
			ang_d[2] = $signed(dfold[24:0]);
			neg_d[2] = 1'b0;
		end
	end

	logic               vld_s1;
	logic signed [24:0] ang_s1 [3];
	logic               neg_s1 [3];
	logic               vld_s2;
	rot_row_t           row_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [50:0] p;
				p = 51'(ang_s1[k]) * 51'(DEG_TO_RAD);
				row_s2[k].x   <= CORDIC_GAIN;
				row_s2[k].y   <= '0;
				row_s2[k].z   <= 33'(p >>> 16);
				row_s2[k].neg <= neg_s1[k];
				ang_s1[k]     <= ang_d[k];
				neg_s1[k]     <= neg_d[k];
			end
		end
	end

	// rotation chain
	rot_row_t rot_c [NSTEP+1];
	logic     rot_v [NSTEP+1];

	assign rot_c[0] = row_s2;
	assign rot_v[0] = vld_s2;

	for (genvar i = 0; i < NSTEP; i++) begin : g_rot
		gcd_rot_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (5'(i)),
			.vld_in (rot_v[i]),
			.row_in (rot_c[i]),
			.vld_q  (rot_v[i+1]),
			.row_q  (rot_c[i+1])
		);
	end

	logic signed [31:0] sn [3];
	logic signed [31:0] cs [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sn[k] = rot_c[NSTEP][k].y[31:0];
			cs[k] = rot_c[NSTEP][k].neg ? 32'(-rot_c[NSTEP][k].x) : rot_c[NSTEP][k].x[31:0];
		end
	end

	// dot product
	logic               vld_s3;
	logic signed [33:0] ss_s3;
	logic signed [33:0] cc_s3;
	logic signed [31:0] cd_s3;
	logic               vld_s4;
	logic signed [34:0] sum_s4;
	logic               vld_s5;
	logic signed [31:0] v_s5;
	logic               vld_s6;
	sqrt_t              sq_s6;

	logic signed [63:0] pss;
	logic signed [63:0] pcc;
	logic signed [63:0] pcd;
	logic signed [63:0] pvv;
	logic signed [34:0] vclamp;

	always_comb begin
		pss    = sn[0] * sn[1];
		pcc    = cs[0] * cs[1];
		pcd    = $signed(cc_s3[31:0]) * cd_s3;
		pvv    = v_s5 * v_s5;
		if (sum_s4 > Q30_ONE) begin
			vclamp = Q30_ONE;
		end else if (sum_s4 < -Q30_ONE) begin
			vclamp = -Q30_ONE;
		end else begin
			vclamp = sum_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s3 <= rot_v[NSTEP];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ss_s3      <= 34'(pss >>> 30);
			cc_s3      <= 34'(pcc >>> 30);
			cd_s3      <= cs[2];
			sum_s4     <= 35'(ss_s3) + 35'(pcd >>> 30);
			v_s5       <= vclamp[31:0];
			sq_s6.rem  <= Q60_ONE - 61'(pvv);
			sq_s6.root <= '0;
			sq_s6.mag  <= v_s5[31] ? 31'(-v_s5) : v_s5[30:0];
			sq_s6.vneg <= v_s5[31];
		end
	end

	// square root chain
	sqrt_t sq_c [SQRT_STEPS+1];
	logic  sq_v [SQRT_STEPS+1];

	assign sq_c[0] = sq_s6;
	assign sq_v[0] = vld_s6;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		gcd_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (5'(i)),
			.vld_in (sq_v[i]),
			.sq_in  (sq_c[i]),
			.vld_q  (sq_v[i+1]),
			.sq_q   (sq_c[i+1])
		);
	end

	// vectoring chain
	vec_t vec_c [NSTEP+1];
	logic vec_v [NSTEP+1];

	assign vec_c[0].x    = 34'(sq_c[SQRT_STEPS].mag);
	assign vec_c[0].y    = 34'(sq_c[SQRT_STEPS].root);
	assign vec_c[0].z    = '0;
	assign vec_c[0].vneg = sq_c[SQRT_STEPS].vneg;
	assign vec_v[0]      = sq_v[SQRT_STEPS];

	for (genvar i = 0; i < NSTEP; i++) begin : g_vec
		gcd_vec_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (5'(i)),
			.vld_in (vec_v[i]),
			.vec_in (vec_c[i]),
			.vld_q  (vec_v[i+1]),
			.vec_q  (vec_c[i+1])
		);
	end

	// angle to distance
	logic signed [34:0] zpos;
	logic signed [34:0] zflip;
	logic [31:0]        ang_d7;
	logic               vld_s7;
	logic [31:0]        ang_s7;
	logic               vld_s8;
	logic [60:0]        prod_s8;
	logic [61:0]        rnd;
	logic [23:0]        len_raw;

	always_comb begin
		zpos  = vec_c[NSTEP].z[32] ? '0 : 35'(vec_c[NSTEP].z);
		zflip = vec_c[NSTEP].vneg ? PI_Q30 - zpos : zpos;
		if (zflip[34]) begin
			ang_d7 = '0;
		end else if (zflip > PI_Q30) begin
			ang_d7 = PI_Q30[31:0];
		end else begin
			ang_d7 = zflip[31:0];
		end
		rnd     = {1'b0, prod_s8} + (62'd1 << 37);
		len_raw = rnd[61:38];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s7    <= vec_v[NSTEP];
			vld_s8    <= vld_s7;
			out_valid <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s7      <= ang_d7;
			prod_s8     <= 61'(ang_s7) * 61'(unit_factor(distance_unit_q));
			path_length <= (len_raw > OUT_MAX) ? OUT_MAX[22:0] : len_raw[22:0];
		end
	end

	a_v_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (v_s5 <= 32'sd1073741824) && (v_s5 >= -32'sd1073741824))
		else $error("dot product out of range");

	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> ({3'b000, ang_s7} <= PI_Q30))
		else $error("central angle above pi");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[SQRT_STEPS] |-> (sq_c[SQRT_STEPS].root <= 61'd1073741824))
		else $error("square root out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s8 && !en) |=> vld_s8)
		else $error("pipeline item lost under stall");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams coordinate pairs through great_circle_distance under random input
// bursts and output stalls, across all distance units, and checks every
// distance against a fixed-point law-of-cosines predictor built in the bench.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gcd_pkg::*;

	localparam longint ONE_Q30 = 64'd1073741824;
	localparam longint PI_FIX = 64'd3373259426;
	localparam longint RAD_PER_DEG = 64'd18740330;
	localparam longint GAIN_Q30 = 64'd652032874;
	localparam longint Q90 = 64'd5898240;
	localparam longint Q180 = 64'd11796480;
	localparam longint Q360 = 64'd23592960;
	localparam int LAT_MAX = 5898240;
	localparam int LON_MAX = 11796480;
	localparam int LATENCY = 9 + NSTEP * 2 + 32;
	localparam longint CYCLE_LIMIT = 400000;

	class distance_board;
		logic [22:0] pending[$];
		int errors;

		function void note_item(logic [22:0] d);
			pending.push_back(d);
		endfunction

		function void check_distance(logic [22:0] got);
			logic [22:0] want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected distance %0d", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: path_length expected %0d actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, out_ready = 0, cfg_valid = 0;
	logic in_ready, out_valid, cfg_ready;
	logic [23:0] first_lat = 0, second_lat = 0;
	logic [24:0] first_lon = 0, second_lon = 0;
	logic [22:0] path_length;
	logic [1:0] cfg_data = 0;
	logic [1:0] unit_now;
	longint cycles = 0;
	int stall_mode = 0;
	distance_board board;

	great_circle_distance dut (.*);

	always #5 clk = ~clk;

	function automatic longint shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic void rotate_deg(longint a, output longint s, output longint c);
		longint x, y, z, dx, dy;
		bit flip;
		x = GAIN_Q30; y = 0; flip = 0;
		if (a > Q90) begin a = Q180 - a; flip = 1; end
		else if (a < -Q90) begin a = -Q180 - a; flip = 1; end
		z = shr(a * RAD_PER_DEG, 16);
		for (int i = 0; i < NSTEP; i++) begin
			dx = shr(y, i); dy = shr(x, i);
			if (z >= 0) begin x -= dx; y += dy; z -= longint'(atan_q30(5'(i))); end
			else begin x += dx; y -= dy; z += longint'(atan_q30(5'(i))); end
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic longint root_of(logic [63:0] n);
		logic [63:0] r, b;
		r = 0; b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin n -= r + b; r = (r >> 1) + b; end
			else r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint arccos_q30(longint v);
		longint x, y, z, dx, dy;
		x = v < 0 ? -v : v;
		y = root_of(64'(ONE_Q30 * ONE_Q30) - 64'(v * v));
		z = 0;
		for (int i = 0; i < NSTEP; i++) begin
			dx = shr(y, i); dy = shr(x, i);
			if (y > 0) begin x += dx; y -= dy; z += longint'(atan_q30(5'(i))); end
			else begin x -= dx; y += dy; z -= longint'(atan_q30(5'(i))); end
		end
		if (z < 0) z = 0;
		if (v < 0) z = PI_FIX - z;
		if (z < 0) z = 0;
		if (z > PI_FIX) z = PI_FIX;
		return z;
	endfunction

	function automatic logic [22:0] predict_distance(logic [23:0] la1, logic [24:0] lo1,
			logic [23:0] la2, logic [24:0] lo2, logic [1:0] unit);
		longint d, s1, c1, s2, c2, sd, cd, dot, ang;
		logic [63:0] len_v, f;
		d = longint'($signed(lo1)) - longint'($signed(lo2));
		if (d < 0) d = -d;
		if (d >= Q360) d -= Q360;
		if (d > Q180) d = Q360 - d;
		rotate_deg(longint'($signed(la1)), s1, c1);
		rotate_deg(longint'($signed(la2)), s2, c2);
		rotate_deg(d, sd, cd);
		dot = shr(s1 * s2, 30) + shr(shr(c1 * c2, 30) * cd, 30);
		if (dot > ONE_Q30) dot = ONE_Q30;
		if (dot < -ONE_Q30) dot = -ONE_Q30;
		ang = arccos_q30(dot);
		case (unit)
			UNIT_KM: f = 64'd417509768;
			UNIT_NM: f = 64'd225287746;
			default: f = 64'd259428542;
		endcase
		len_v = (64'(ang) * f + (64'd1 << 37)) >> 38;
		if (len_v > 64'd8388607) len_v = 64'd8388607;
		return len_v[22:0];
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_distance(path_length);

	// receiver stall pattern
	always @(negedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= (cycles % 7 < 3);
		endcase
		if (cycles % 300 == 0)
			stall_mode <= $urandom_range(0, 2);
	end

	task automatic write_unit(logic [1:0] u);
		@(negedge clk);
		cfg_data <= u;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		unit_now = u;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pair(int la1, int lo1, int la2, int lo2);
		first_lat <= la1[23:0];
		first_lon <= lo1[24:0];
		second_lat <= la2[23:0];
		second_lon <= lo2[24:0];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_item(predict_distance(la1[23:0], lo1[24:0], la2[23:0], lo2[24:0],
			unit_now));
		@(negedge clk);
	endtask

	task automatic pause_input(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	function automatic int rand_coord(int lim);
		case ($urandom_range(0, 5))
			0: return lim;
			1: return -lim;
			2: return $urandom_range(0, 64) - 32;
			default: return int'($urandom_range(0, 2 * lim)) - lim;
		endcase
	endfunction

	task automatic random_run(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 30);
			while (burst > 0 && n > 0) begin
				if ($urandom_range(0, 9) == 0)
					// a point on the zero meridian against the origin, at times near or at it
					send_pair(rand_coord(LAT_MAX), 0, 0, 0);
				else
					send_pair(rand_coord(LAT_MAX), rand_coord(LON_MAX),
						rand_coord(LAT_MAX), rand_coord(LON_MAX));
				burst--; n--;
			end
			if ($urandom_range(0, 2) != 0)
				pause_input($urandom_range(1, 12));
		end
	endtask

	initial begin
		board = new();
		unit_now = UNIT_KM;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: extremes, antipodes, wraps, poles, same point
		send_pair(0, 0, 0, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		send_pair(0, LON_MAX, 0, -LON_MAX);
		send_pair(0, -LON_MAX, 0, LON_MAX);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
		send_pair(LAT_MAX, 123456, LAT_MAX, -654321);
		send_pair(0, 1, 0, 0);
		send_pair(1, 0, 0, 0);
		send_pair(3000000, 5000000, -3000000, -6796480);
		send_pair(-1, -1, -1, -1);
		send_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
		send_pair(0, 0, 0, 11796479);
		send_pair(-8388608, -16777216, 8388607, 16777215);
		send_pair(8388607, 16777215, -8388608, 0);
		send_pair(7000000, -14000000, -7000000, 14000000);
		drain();
		write_unit(UNIT_MI);
		send_pair(0, 0, 0, LON_MAX);
		random_run(200);
		drain();
		write_unit(UNIT_NM);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		random_run(200);
		drain();
		write_unit(2'd3);
		send_pair(0, 0, 0, LON_MAX);
		random_run(150);
		drain();
		write_unit(UNIT_KM);
		random_run(250);
		drain();
		if (board.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

// File: great_circle_distance.f
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_rot_cell.sv
hw/rtl/gcd_sqrt_cell.sv
hw/rtl/gcd_vec_cell.sv
hw/rtl/great_circle_distance.sv
tb/testbench.sv
